// ===== hw/rtl/triangle_circumcenter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the triangle circumcentre block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CIRCUMCENTER_MACROS_SVH
`define TRIANGLE_CIRCUMCENTER_MACROS_SVH

// An antecedent on the current edge implies a consequent on the same edge.
`define TRIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tric check failed");

// An antecedent on the current edge implies a consequent on the next edge.
`define TRIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tric check failed");

`endif

// ===== hw/rtl/tric_pkg.sv =====
// ----------------------------------------------------------------------------
// tric_pkg
// Widths, beat types and the divider step shared by the circumcentre block.
// ----------------------------------------------------------------------------
`default_nettype none

package tric_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int FIELD_W    = 16;
    localparam int OUT_W      = 32;

    // Widths of the intermediate values, all exact.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int C_W    = SQ_W + 2;
    localparam int DET_W  = 2 * DIFF_W + 1;
    localparam int NUM_W  = DIFF_W + C_W + 1;
    localparam int MAG_W  = NUM_W + FRAC_BITS;
    localparam int DIV_W  = DET_W + 1;
    localparam int Q_W    = OUT_W;
    localparam int CMP_W  = (MAG_W > DIV_W + Q_W) ? MAG_W : DIV_W + Q_W;

    // One division lane: partial remainder, and a word that holds the
    // numerator bits still to come on top and the quotient bits below.
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [Q_W-1:0]   nq;
        logic             neg;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        t_lane            x;
        t_lane            y;
        logic [DIV_W-1:0] div;
        logic             collinear;
    } t_beat;

    // One restoring division step.
    function automatic t_lane div_step(input t_lane l, input logic [DIV_W-1:0] d);
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        t_lane          r;
        trial = {l.rem, l.nq[Q_W-1]};
        diff  = trial - {1'b0, d};
        r     = l;
        if (trial >= {1'b0, d}) begin
            r.rem = diff[DIV_W-1:0];
            r.nq  = {l.nq[Q_W-2:0], 1'b1};
        end else begin
            r.rem = trial[DIV_W-1:0];
            r.nq  = {l.nq[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tric_front.sv =====
// ----------------------------------------------------------------------------
// tric_front
// Five-stage front end: differences, squares, determinant, numerators,
// magnitudes and the quotient overflow test.
// ----------------------------------------------------------------------------
`default_nettype none

module tric_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [6*tric_pkg::FIELD_W-1:0] i_data,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output tric_pkg::t_beat                   o_beat
);

    localparam int DW = tric_pkg::DIFF_W;
    localparam int SW = tric_pkg::SQ_W;
    localparam int CW = tric_pkg::C_W;
    localparam int EW = tric_pkg::DET_W;
    localparam int NW = tric_pkg::NUM_W;
    localparam int MW = tric_pkg::MAG_W;
    localparam int VW = tric_pkg::DIV_W;
    localparam int QW = tric_pkg::Q_W;
    localparam int KW = tric_pkg::CMP_W;
    localparam int FW = tric_pkg::FIELD_W;
    localparam int XW = tric_pkg::COORD_BITS;

    logic [4:0] r_valid;
    logic [4:0] adv;

    // Each stage moves when it is empty or the one after it moves.
    assign adv[4]  = !r_valid[4] || i_ready;
    assign adv[3]  = !r_valid[3] || adv[4];
    assign adv[2]  = !r_valid[2] || adv[3];
    assign adv[1]  = !r_valid[1] || adv[2];
    assign adv[0]  = !r_valid[0] || adv[1];
    assign o_ready = adv[0];
    assign o_valid = r_valid[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) r_valid[0] <= i_valid;
            if (adv[1]) r_valid[1] <= r_valid[0];
            if (adv[2]) r_valid[2] <= r_valid[1];
            if (adv[3]) r_valid[3] <= r_valid[2];
            if (adv[4]) r_valid[4] <= r_valid[3];
        end
    end

    // Coordinates: low bits of each field, taken as signed.
    logic signed [XW-1:0] ax, ay, bx, by, cx, cy;
    assign ax = $signed(XW'(i_data[0*FW +: FW]));
    assign ay = $signed(XW'(i_data[1*FW +: FW]));
    assign bx = $signed(XW'(i_data[2*FW +: FW]));
    assign by = $signed(XW'(i_data[3*FW +: FW]));
    assign cx = $signed(XW'(i_data[4*FW +: FW]));
    assign cy = $signed(XW'(i_data[5*FW +: FW]));

    // Stage 1: edge differences and squares.
    logic signed [DW-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [SW-1:0] r1_sax, r1_say, r1_sbx, r1_sby, r1_scx, r1_scy;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_a1  <= DW'(bx) - DW'(ax);
            r1_b1  <= DW'(by) - DW'(ay);
            r1_a2  <= DW'(cx) - DW'(bx);
            r1_b2  <= DW'(cy) - DW'(by);
            r1_sax <= SW'(ax * ax);
            r1_say <= SW'(ay * ay);
            r1_sbx <= SW'(bx * bx);
            r1_sby <= SW'(by * by);
            r1_scx <= SW'(cx * cx);
            r1_scy <= SW'(cy * cy);
        end
    end

    // Stage 2: doubled bisector right-hand sides and determinant products.
    logic signed [DW-1:0] r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [CW-1:0] r2_c1, r2_c2;
    logic signed [EW-1:0] r2_d1, r2_d2;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_a1 <= r1_a1;
            r2_b1 <= r1_b1;
            r2_a2 <= r1_a2;
            r2_b2 <= r1_b2;
            r2_c1 <= (CW'(r1_sbx) - CW'(r1_sax)) + (CW'(r1_sby) - CW'(r1_say));
            r2_c2 <= (CW'(r1_scx) - CW'(r1_sbx)) + (CW'(r1_scy) - CW'(r1_sby));
            r2_d1 <= EW'(r1_a1 * r1_b2);
            r2_d2 <= EW'(r1_a2 * r1_b1);
        end
    end

    // Stage 3: determinant and the Cramer numerator products.
    logic signed [EW-1:0] r3_det;
    logic signed [NW-1:0] r3_xa, r3_xb, r3_ya, r3_yb;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_det <= r2_d1 - r2_d2;
            r3_xa  <= NW'(r2_b2 * r2_c1);
            r3_xb  <= NW'(r2_b1 * r2_c2);
            r3_ya  <= NW'(r2_a1 * r2_c2);
            r3_yb  <= NW'(r2_a2 * r2_c1);
        end
    end

    // Stage 4: numerators.
    logic signed [EW-1:0] r4_det;
    logic signed [NW-1:0] r4_nx, r4_ny;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_det <= r3_det;
            r4_nx  <= r3_xa - r3_xb;
            r4_ny  <= r3_ya - r3_yb;
        end
    end

    // Stage 5: scaled magnitudes, signs, divisor and the overflow test.
    logic [NW-1:0] abs_x, abs_y;
    logic [MW-1:0] mag_x, mag_y;
    logic [EW-1:0] abs_d;
    logic [VW-1:0] div;
    logic [KW-1:0] lim;

    assign abs_x = r4_nx[NW-1] ? NW'(-r4_nx) : NW'(r4_nx);
    assign abs_y = r4_ny[NW-1] ? NW'(-r4_ny) : NW'(r4_ny);
    assign abs_d = r4_det[EW-1] ? EW'(-r4_det) : EW'(r4_det);
    assign mag_x = MW'(abs_x) << tric_pkg::FRAC_BITS;
    assign mag_y = MW'(abs_y) << tric_pkg::FRAC_BITS;
    assign div   = {abs_d, 1'b0};
    assign lim   = KW'(div) << QW;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            o_beat.x.rem     <= VW'(mag_x >> QW);
            o_beat.x.nq      <= QW'(mag_x);
            o_beat.x.neg     <= r4_nx[NW-1] ^ r4_det[EW-1];
            o_beat.x.ovf     <= KW'(mag_x) >= lim;
            o_beat.y.rem     <= VW'(mag_y >> QW);
            o_beat.y.nq      <= QW'(mag_y);
            o_beat.y.neg     <= r4_ny[NW-1] ^ r4_det[EW-1];
            o_beat.y.ovf     <= KW'(mag_y) >= lim;
            o_beat.div       <= div;
            o_beat.collinear <= (r4_det == '0);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tric_div_cell.sv =====
// ----------------------------------------------------------------------------
// tric_div_cell
// One cell of the divider chain: one quotient bit for each of the two lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module tric_div_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tric_pkg::t_beat i_beat,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output tric_pkg::t_beat      o_beat
);

    logic r_valid;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Both lanes share the divisor.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            o_beat.x         <= tric_pkg::div_step(i_beat.x, i_beat.div);
            o_beat.y         <= tric_pkg::div_step(i_beat.y, i_beat.div);
            o_beat.div       <= i_beat.div;
            o_beat.collinear <= i_beat.collinear;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_circumcenter.sv =====
// ----------------------------------------------------------------------------
// triangle_circumcenter
// Circumcentre of a triangle from the intersection of two perpendicular
// bisectors, in signed fixed point, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_axis   in         tdata: a_x, a_y, b_x, b_y, c_x, c_y (16 bits each)
//  m_axis   out        tdata: center_x, center_y; tuser: collinear, saturated
//
//  The pipeline has five front-end stages, 32 divider cells (one quotient
//  bit each) and the output register; one beat is taken per cycle unless stalled.
//  Every stage holds its own valid bit, so bubbles close up under a stall.
//  Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcenter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // a_x[15:0], a_y[31:16], b_x[47:32], b_y[63:48], c_x[79:64], c_y[95:80]
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // center_x[31:0], center_y[63:32]
    output logic [63:0]      m_axis_tdata,
    // collinear[0], saturated[1]
    output logic [1:0]       m_axis_tuser
);

    localparam int NC = tric_pkg::Q_W;
    localparam int QW = tric_pkg::Q_W;

    tric_pkg::t_beat beat  [NC+1];
    logic            valid [NC+1];
    logic            ready [NC+1];

    tric_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (valid[0]),
        .i_ready (ready[0]),
        .o_beat  (beat[0])
    );

    // Divider chain, most significant quotient bit first.
    for (genvar k = 0; k < NC; k++) begin : g_cell
        tric_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .o_ready (ready[k]),
            .i_beat  (beat[k]),
            .o_valid (valid[k+1]),
            .i_ready (ready[k+1]),
            .o_beat  (beat[k+1])
        );
    end

    // Output register.
    logic r_out_valid;
    assign ready[NC]     = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ready[NC]) begin
            r_out_valid <= valid[NC];
        end
    end

    // Clip, apply the sign and zero the coordinates of a degenerate triangle.
    logic [QW-1:0] lim_x, lim_y, val_x, val_y, res_x, res_y;
    logic          sat_x, sat_y;

    assign lim_x = beat[NC].x.neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    assign lim_y = beat[NC].y.neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    assign sat_x = beat[NC].x.ovf || (beat[NC].x.nq > lim_x);
    assign sat_y = beat[NC].y.ovf || (beat[NC].y.nq > lim_y);
    assign val_x = sat_x ? lim_x : beat[NC].x.nq;
    assign val_y = sat_y ? lim_y : beat[NC].y.nq;
    assign res_x = beat[NC].x.neg ? QW'(-val_x) : val_x;
    assign res_y = beat[NC].y.neg ? QW'(-val_y) : val_y;

    always_ff @(posedge i_clk) begin
        if (ready[NC]) begin
            if (beat[NC].collinear) begin
                m_axis_tdata <= '0;
                m_axis_tuser <= 2'b01;
            end else begin
                m_axis_tdata <= {res_y, res_x};
                m_axis_tuser <= {sat_x || sat_y, 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tric_checker.sv =====
// ----------------------------------------------------------------------------
// tric_checker
// Port-level checks on the circumcentre result stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_circumcenter_macros.svh"

module tric_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // Beat classes and coordinates sitting at a range bound.
    logic col_beat, sat_beat, x_bound, y_bound;

    assign col_beat = m_axis_tvalid && m_axis_tuser[0];
    assign sat_beat = m_axis_tvalid && m_axis_tuser[1];
    assign x_bound  = (m_axis_tdata[31:0] == 32'h7fffffff)
                   || (m_axis_tdata[31:0] == 32'h80000000);
    assign y_bound  = (m_axis_tdata[63:32] == 32'h7fffffff)
                   || (m_axis_tdata[63:32] == 32'h80000000);

    // A degenerate triangle gives zero coordinates.
    `TRIC_ASSERT_IMPL(a_col_zero, i_clk, i_rst_n, col_beat, m_axis_tdata == 64'd0)

    // A degenerate triangle never reports clipping.
    `TRIC_ASSERT_IMPL(a_col_nosat, i_clk, i_rst_n, col_beat, !m_axis_tuser[1])

    // A clipped beat carries at least one coordinate at a range bound.
    `TRIC_ASSERT_IMPL(a_sat_bound, i_clk, i_rst_n, sat_beat, x_bound || y_bound)

    // A stalled result beat stays offered.
    `TRIC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind triangle_circumcenter tric_checker u_tric_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/triangle_circumcenter_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_circumcenter_tb
// Streams triangles into the circumcentre block with random gaps on both
// sides and compares each output beat with a predicted centre, worked out in
// exact wide integer arithmetic with truncating fixed-point division.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcenter_tb;

    typedef struct packed {
        logic signed [15:0] c_y;
        logic signed [15:0] c_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_x;
    } t_tri;

    typedef struct packed {
        logic [31:0] cy;
        logic [31:0] cx;
        logic        sat;
        logic        col;
    } t_centre;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    t_tri    tri_q[$];
    t_centre centre_q[$];
    int      errors = 0;
    int      n_sent = 0;
    int      n_got = 0;
    int      n_col = 0;
    int      n_sat = 0;
    bit      stim_done = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;

    triangle_circumcenter dut (.*);

    always #5 i_clk = ~i_clk;

    // Quotient of num * 2^8 by den, truncated toward zero and clipped.
    function automatic logic [31:0] fixed_quot(input logic signed [127:0] num,
                                               input logic signed [127:0] den,
                                               inout logic sat);
        logic [127:0] mag;
        logic [127:0] d;
        logic [127:0] q;
        logic         neg;
        logic [127:0] lim;
        neg = (num < 0) != (den < 0);
        mag = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        q   = (mag << 8) / d;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            sat = 1'b1;
            q   = lim;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic t_centre circumcentre(input t_tri t);
        logic signed [127:0] ax, ay, bx, by, cx, cy, a1, b1, a2, b2, c1, c2, det;
        t_centre r;
        logic    sat;
        ax = t.a_x; ay = t.a_y; bx = t.b_x; by = t.b_y; cx = t.c_x; cy = t.c_y;
        a1 = bx - ax; b1 = by - ay; a2 = cx - bx; b2 = cy - by;
        c1 = bx*bx - ax*ax + by*by - ay*ay;
        c2 = cx*cx - bx*bx + cy*cy - by*by;
        det = a1*b2 - a2*b1;
        r = '0;
        sat = 1'b0;
        if (det == 0) begin
            r.col = 1'b1;
        end else begin
            r.cx = fixed_quot(b2*c1 - b1*c2, det*2, sat);
            r.cy = fixed_quot(a1*c2 - a2*c1, det*2, sat);
            r.sat = sat;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch on beat %0d: %s got %h expected %h", n_got, what, got, want);
    endtask

    // Driver: presents queued triangles with a random gap after each one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                centre_q.push_back(circumcentre(t_tri'(s_axis_tdata)));
                n_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (tri_q.size() > 0) begin
                s_axis_tdata  <= tri_q.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and comparison of every output beat.
    always @(posedge i_clk) begin
        t_centre want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (centre_q.size() == 0) begin
                    report("unexpected beat", m_axis_tdata[31:0], '0);
                end else begin
                    want = centre_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.cx)
                        report("center_x", m_axis_tdata[31:0], want.cx);
                    if (m_axis_tdata[63:32] !== want.cy)
                        report("center_y", m_axis_tdata[63:32], want.cy);
                    if (m_axis_tuser[0] !== want.col)
                        report("collinear", m_axis_tuser[0], want.col);
                    if (m_axis_tuser[1] !== want.sat)
                        report("saturated", m_axis_tuser[1], want.sat);
                    n_col += want.col;
                    n_sat += want.sat;
                end
                n_got++;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
        end
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF - 16'($urandom_range(0, 3));
            1:       return 16'sh8000 + 16'($urandom_range(0, 3));
            2:       return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_tri mk_tri(input int ax, ay, bx, by, cx, cy);
        t_tri t;
        t.a_x = 16'(ax); t.a_y = 16'(ay); t.b_x = 16'(bx);
        t.b_y = 16'(by); t.c_x = 16'(cx); t.c_y = 16'(cy);
        return t;
    endfunction

    initial begin
        t_tri t;
        int   k;
        int   n_total;
        // Directed: plain triangles, extremes, collinear and coincident points,
        // and near-degenerate triangles that drive the result out of range.
        tri_q.push_back(mk_tri(0, 0, 4, 0, 0, 4));
        tri_q.push_back(mk_tri(-3, 1, 5, 7, 2, -9));
        tri_q.push_back(mk_tri(1, 1, 1, 1, 1, 1));
        tri_q.push_back(mk_tri(0, 0, 1, 1, 2, 2));
        tri_q.push_back(mk_tri(-32768, -32768, 0, 0, 32767, 32767));
        tri_q.push_back(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767));
        tri_q.push_back(mk_tri(32767, 32767, -32768, 32767, 32767, -32768));
        tri_q.push_back(mk_tri(-32768, 0, 32767, 0, 0, 1));
        tri_q.push_back(mk_tri(-32768, 0, 32767, 1, 0, 0));
        tri_q.push_back(mk_tri(-32768, -32767, 32767, 32767, -32767, -32766));
        tri_q.push_back(mk_tri(32767, -32768, -32768, 32767, 32766, -32766));
        tri_q.push_back(mk_tri(0, 0, 1, 0, 0, 1));
        tri_q.push_back(mk_tri(0, 0, -1, 0, 0, -1));
        tri_q.push_back(mk_tri(5, 5, 5, 5, 9, 2));
        tri_q.push_back(mk_tri(-1, -1, -1, -1, -1, -1));
        tri_q.push_back(mk_tri(32767, 32767, 32767, 32767, -32768, -32768));
        tri_q.push_back(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768));
        tri_q.push_back(mk_tri(100, 0, 0, 100, -100, 0));
        // Random triangles; some built collinear, some nearly so.
        for (int i = 0; i < 1800; i++) begin
            t = {rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord()};
            k = $urandom_range(0, 9);
            if (k == 0) begin
                t.c_x = t.b_x + (t.b_x - t.a_x);
                t.c_y = t.b_y + (t.b_y - t.a_y);
            end else if (k == 1) begin
                t.b_x = t.a_x + 16'($urandom_range(0, 2));
                t.b_y = t.a_y + 16'($urandom_range(0, 2));
            end else if (k == 2) begin
                t.c_x = t.b_x + (t.b_x - t.a_x) + 16'($urandom_range(0, 1));
                t.c_y = t.b_y + (t.b_y - t.a_y);
            end
            tri_q.push_back(t);
        end
        n_total = tri_q.size();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_sent == n_total);
        wait (centre_q.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("%0d triangles sent, %0d centres checked", n_sent, n_got);
        $display("%0d collinear and %0d clipped results seen", n_col, n_sat);
        if (errors == 0 && centre_q.size() == 0) begin
            $display("triangle_circumcenter_tb OK");
        end else begin
            $display("triangle_circumcenter_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", centre_q.size());
        $display("triangle_circumcenter_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
